>>> sv/dmp_pkg.sv
package dmp_pkg;

    // Field widths of the received character and of the result fields.
    localparam int BYTE_W     = 8;
    localparam int EVENT_W    = 3;
    localparam int TYPE_W     = 4;
    localparam int PAYLOAD_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Register indexes of the configuration write channel.
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_LIMIT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 2'd1;

    // Hard caps on the section lengths, applied on top of the limit registers.
    localparam logic [TYPE_W-1:0]    MAX_TYPE_LEN    = 4'd15;
    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_LEN = 8'd255;

    typedef enum logic [EVENT_W-1:0] {
        EV_IGNORED      = 3'd0,
        EV_START        = 3'd1,
        EV_TYPE_CHAR    = 3'd2,
        EV_TYPE_END     = 3'd3,
        EV_PAYLOAD_CHAR = 3'd4,
        EV_COMPLETE     = 3'd5,
        EV_ABORTED      = 3'd6
    } event_t;

    typedef struct packed {
        event_t                event_res;
        logic [BYTE_W-1:0]     char_index;
        logic [BYTE_W-1:0]     char_value;
        logic                  message_done;
        logic [TYPE_W-1:0]     type_length;
        logic [PAYLOAD_W-1:0]  payload_length;
    } result_t;

    typedef struct packed {
        logic [TYPE_W-1:0]    type_limit;
        logic [PAYLOAD_W-1:0] payload_limit;
    } limits_t;

endpackage

>>> sv/dmp_cfg_regs.sv
module dmp_cfg_regs
    import dmp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output limits_t                limits
);

    localparam logic [TYPE_W-1:0]    TYPE_LIMIT_RESET    = 4'd6;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_LIMIT_RESET = 8'd100;

    limits_t limits_reg;

    assign cfg_ready = 1'b1;
    assign limits    = limits_reg;

    // Writes to indexes past the two registers are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.type_limit    <= TYPE_LIMIT_RESET;
            limits_reg.payload_limit <= PAYLOAD_LIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_TYPE_LIMIT) begin
                limits_reg.type_limit <= cfg_data[TYPE_W-1:0];
            end else if (cfg_index == REG_PAYLOAD_LIMIT) begin
                limits_reg.payload_limit <= cfg_data[PAYLOAD_W-1:0];
            end
        end
    end

endmodule

>>> sv/dmp_framer.sv
module dmp_framer
    import dmp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  limits_t           limits,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;

    phase_t                phase_reg, phase_next;
    logic [TYPE_W-1:0]     type_count_reg, type_count_next;
    logic [PAYLOAD_W-1:0]  payload_count_reg, payload_count_next;
    logic                  out_valid_reg;
    result_t               out_res_reg, res_next;
    logic [TYPE_W-1:0]     type_lim;
    logic [PAYLOAD_W-1:0]  payload_lim;
    logic                  in_fire;

    assign type_lim    = (limits.type_limit < MAX_TYPE_LEN) ?
                         limits.type_limit : MAX_TYPE_LEN;
    assign payload_lim = (limits.payload_limit < MAX_PAYLOAD_LEN) ?
                         limits.payload_limit : MAX_PAYLOAD_LEN;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb begin
        phase_next         = phase_reg;
        type_count_next    = type_count_reg;
        payload_count_next = payload_count_reg;
        res_next           = '0;
        res_next.event_res = EV_IGNORED;

        unique case (phase_reg)
            PH_TYPE: begin
                // A comma is taken even when the type is already full.
                if (in_byte == CH_COMMA) begin
                    phase_next         = PH_PAYLOAD;
                    payload_count_next = '0;
                    res_next.event_res = EV_TYPE_END;
                end else if (type_count_reg >= type_lim) begin
                    phase_next         = PH_HUNT;
                    type_count_next    = '0;
                    res_next.event_res = EV_ABORTED;
                end else if (in_byte == CH_STAR) begin
                    phase_next            = PH_HUNT;
                    res_next.event_res    = EV_COMPLETE;
                    res_next.message_done = 1'b1;
                    res_next.type_length  = type_count_reg;
                end else begin
                    res_next.event_res  = EV_TYPE_CHAR;
                    res_next.char_index = BYTE_W'(type_count_reg);
                    res_next.char_value = in_byte;
                    type_count_next     = type_count_reg + 1'b1;
                end
            end
            PH_PAYLOAD: begin
                // The closing star wins over the length check.
                if (in_byte == CH_STAR) begin
                    phase_next              = PH_HUNT;
                    res_next.event_res      = EV_COMPLETE;
                    res_next.message_done   = 1'b1;
                    res_next.type_length    = type_count_reg;
                    res_next.payload_length = payload_count_reg;
                end else if (payload_count_reg >= payload_lim) begin
                    phase_next         = PH_HUNT;
                    payload_count_next = '0;
                    res_next.event_res = EV_ABORTED;
                end else begin
                    res_next.event_res  = EV_PAYLOAD_CHAR;
                    res_next.char_index = BYTE_W'(payload_count_reg);
                    res_next.char_value = in_byte;
                    payload_count_next  = payload_count_reg + 1'b1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (in_byte == CH_DOLLAR) begin
                    phase_next         = PH_TYPE;
                    type_count_next    = '0;
                    res_next.event_res = EV_START;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            type_count_reg    <= '0;
            payload_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else if (in_fire) begin
            phase_reg         <= phase_next;
            type_count_reg    <= type_count_next;
            payload_count_reg <= payload_count_next;
            out_res_reg       <= res_next;
            out_valid_reg     <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> sv/delimited_message_parser.sv
// Frames messages of the form $TYPE,PAYLOAD* from a stream of received
// characters, one character per transfer on the s_ side, and returns exactly
// one result transfer on the m_ side for every character taken. The result
// carries an event code in m_tuser (ignored, start, type character, type end,
// payload character, complete, aborted), the character and its position for
// type and payload characters so that a downstream store can capture them,
// and on the closing '*' a completion flag on m_tlast together with the type
// and payload lengths. A type or payload that grows past its limit aborts the
// message and the parser goes back to hunting for '$'. The block takes one
// character per clock cycle, sustained, while the m_ side accepts its results; a
// character is held in the input register after its transfer, and the parse logic
// then loads its result into the result register, from which the result transfer
// takes place. The limits are written through the cfg_ port (index 0: type limit,
// index 1: payload limit); the user must write them only while no character is in
// flight, which the block itself does not enforce.
module delimited_message_parser
    import dmp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Received characters.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    // Parse results.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [7:0] char_index, [15:8] char_value,
                                              // [19:16] type_length,
                                              // [27:20] payload_length, [31:28] zero
    output logic                   m_tlast,   // message_done
    output logic [2:0]             m_tuser,   // [2:0] event_res
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    limits_t           limits;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              framer_ready;
    result_t           res;

    dmp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // The input register holds one character. It refills in the same cycle
    // that the framer consumes it, so a stream of back-to-back transfers
    // flows through without bubbles.
    assign s_tready = !in_valid_reg || framer_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
            in_byte_reg  <= s_tdata;
        end else if (framer_ready) begin
            in_valid_reg <= 1'b0;
        end
    end

    // The framer keeps the parse phase and both counters, and owns the
    // result register. It advances on a character whenever the result
    // register is empty or is being emptied in the same cycle.
    dmp_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (framer_ready),
        .in_byte   (in_byte_reg),
        .limits    (limits),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result fields onto the stream ports.
    assign m_tdata = {4'd0, res.payload_length, res.type_length,
                      res.char_value, res.char_index};
    assign m_tlast = res.message_done;
    assign m_tuser = res.event_res;

endmodule

>>> verif/tb_top.sv
module tb_top
    import dmp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Delimiter characters of the $TYPE,PAYLOAD* framing.
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_STAR   = "*";

    // Register indexes of the cfg_ write channel that decode to nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_LO   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_HI   = 2'd3;

    // Extra wait after the last result comes back, covering the input and result registers.
    localparam int SETTLE_CYCLES = 6;
    // Length of the long receiver hold-off, long enough to fill every buffer in the block.
    localparam int HOLD_CYCLES   = 200;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;   // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;          // [7:0] char_index, [15:8] char_value,
                                              // [19:16] type_length, [27:20] payload_length
    logic                   m_tlast;          // message_done
    logic [2:0]             m_tuser;          // [2:0] event_res
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow copy of the parser: limit registers and framing state.
    logic [TYPE_W-1:0]    type_lim;
    logic [PAYLOAD_W-1:0] payload_lim;
    phase_t               frame_phase;
    logic [TYPE_W-1:0]    type_cnt;
    logic [PAYLOAD_W-1:0] payload_cnt;

    // Predicted results in transfer order, and the number of framing events seen so far.
    result_t pending_results[$];
    int      framed_count = 0;
    int      error_count  = 0;

    // Stimulus knobs. The receiver knobs are only changed with nonblocking writes at the
    // falling edge, so the receiver process always sees them at the next falling edge.
    int src_idle_pct  = 15;
    int sink_idle_pct = 75;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cur_tlim      = 6;
    int cur_plim      = 100;

    delimited_message_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Every mismatch goes through here: one line each for the first 50, and the count decides the verdict.
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("%0t ns ERROR %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_error($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    // Frames one received character exactly as the parser should, updating the shadow
    // state and returning the result transfer it must produce.
    function automatic result_t frame_byte(input logic [7:0] rx);
        result_t              res;
        logic [TYPE_W-1:0]    tlim;
        logic [PAYLOAD_W-1:0] plim;
        res  = '0;
        tlim = (type_lim < MAX_TYPE_LEN) ? type_lim : MAX_TYPE_LEN;
        plim = (payload_lim < MAX_PAYLOAD_LEN) ? payload_lim : MAX_PAYLOAD_LEN;
        case (frame_phase)
            PH_TYPE: begin
                // A comma is honored even with a full type; the limit wins over '*'.
                if (rx == CH_COMMA) begin
                    frame_phase   = PH_PAYLOAD;
                    payload_cnt   = '0;
                    res.event_res = EV_TYPE_END;
                end else if (type_cnt >= tlim) begin
                    frame_phase   = PH_HUNT;
                    type_cnt      = '0;
                    res.event_res = EV_ABORTED;
                end else if (rx == CH_STAR) begin
                    frame_phase      = PH_HUNT;
                    res.event_res    = EV_COMPLETE;
                    res.message_done = 1'b1;
                    res.type_length  = type_cnt;
                end else begin
                    res.event_res  = EV_TYPE_CHAR;
                    res.char_index = {4'd0, type_cnt};
                    res.char_value = rx;
                    type_cnt       = type_cnt + 1'b1;
                end
            end
            PH_PAYLOAD: begin
                // Here '*' is tested first, so a full payload still closes normally.
                if (rx == CH_STAR) begin
                    frame_phase        = PH_HUNT;
                    res.event_res      = EV_COMPLETE;
                    res.message_done   = 1'b1;
                    res.type_length    = type_cnt;
                    res.payload_length = payload_cnt;
                end else if (payload_cnt >= plim) begin
                    frame_phase   = PH_HUNT;
                    payload_cnt   = '0;
                    res.event_res = EV_ABORTED;
                end else begin
                    res.event_res  = EV_PAYLOAD_CHAR;
                    res.char_index = payload_cnt;
                    res.char_value = rx;
                    payload_cnt    = payload_cnt + 1'b1;
                end
            end
            default: begin
                // Hunting; the unused phase code behaves the same way.
                frame_phase = PH_HUNT;
                if (rx == CH_DOLLAR) begin
                    frame_phase   = PH_TYPE;
                    type_cnt      = '0;
                    res.event_res = EV_START;
                end
            end
        endcase
        return res;
    endfunction

    // Watches all three channels at the rising edge. Register writes are applied first,
    // then an accepted character is predicted, then an accepted result is checked.
    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (!aresetn) begin
            type_lim    = 4'd6;
            payload_lim = 8'd100;
            frame_phase = PH_HUNT;
            type_cnt    = '0;
            payload_cnt = '0;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TYPE_LIMIT: begin
                        type_lim = cfg_data[TYPE_W-1:0];
                    end
                    REG_PAYLOAD_LIMIT: begin
                        payload_lim = cfg_data[PAYLOAD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = frame_byte(s_tdata);
                if (want.event_res != EV_IGNORED) begin
                    framed_count++;
                end
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                seen.event_res      = event_t'(m_tuser);
                seen.char_index     = m_tdata[7:0];
                seen.char_value     = m_tdata[15:8];
                seen.type_length    = m_tdata[19:16];
                seen.payload_length = m_tdata[27:20];
                seen.message_done   = m_tlast;
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result transfer with nothing expected, event %0d",
                                         m_tuser));
                end else begin
                    want = pending_results.pop_front();
                    check_field("event_res", seen.event_res, want.event_res);
                    check_field("char_index", seen.char_index, want.char_index);
                    check_field("char_value", seen.char_value, want.char_value);
                    check_field("message_done", seen.message_done, want.message_done);
                    check_field("type_length", seen.type_length, want.type_length);
                    check_field("payload_length", seen.payload_length, want.payload_length);
                    check_field("tdata padding", m_tdata[31:28], 0);
                end
            end
        end
    end

    // Receiver: random ready at the falling edge, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offers one character, with random idle cycles ahead of it, and returns at the falling
    // edge after its transfer. The caller either sends the next character or rests the
    // channel at that same edge, so a character is never taken twice.
    task automatic send_byte(input logic [7:0] rx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i]);
        end
    endtask

    // A random body character that cannot end its section early.
    function automatic logic [7:0] body_char(input bit in_type);
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_STAR || (in_type && c == CH_COMMA));
        return c;
    endfunction

    // Mostly random bytes, with the delimiters weighted up so that they land in every phase.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0:       return CH_DOLLAR;
            1:       return CH_COMMA;
            2:       return CH_STAR;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_message(input int tlen, input int plen, input bit has_payload,
                                input bit closed);
        send_byte(CH_DOLLAR);
        repeat (tlen) send_byte(body_char(1'b1));
        if (has_payload) begin
            send_byte(CH_COMMA);
            repeat (plen) send_byte(body_char(1'b0));
        end
        if (closed) begin
            send_byte(CH_STAR);
        end
    endtask

    // Stops offering characters and waits until every predicted result has come back,
    // then lets the pipeline settle so the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Both limits are written on an idle block; the type limit carries random upper bits,
    // which the register must drop.
    task automatic set_limits(input int tl, input int pl);
        drain();
        cfg_write(REG_TYPE_LIMIT, {4'($urandom), 4'(tl)});
        cfg_write(REG_PAYLOAD_LIMIT, 8'(pl));
        cur_tlim = tl;
        cur_plim = pl;
    endtask

    // Reset limits: field extremes, every event code, and the delimiter corner cases.
    task automatic test_directed();
        send_byte(8'h00);           // ignored while hunting
        send_byte(8'hFF);
        send_text("*$AB");          // a stray '*' is ignored; '$' starts a message
        send_byte(8'hFF);
        send_text("$QZ,");          // a '$' inside the type is data; comma on a full type
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$,*");           // '$' and ',' are payload data; '*' completes
        send_text("$T*");           // '*' right after the type: empty payload
        send_text("$ABCDEF*");      // '*' on a full type aborts
    endtask

    task automatic test_limits();
        // With zero limits the first body character aborts, but the delimiters that are
        // tested ahead of the limit still work.
        set_limits(0, 0);
        send_text("$A");
        send_text("$,*");
        send_text("$*");
        send_text("$,X*");
        // One character per section.
        set_limits(1, 1);
        send_message(1, 1, 1'b1, 1'b1);
        send_message(2, 0, 1'b1, 1'b1);
        send_message(1, 2, 1'b1, 1'b1);
        send_text("$A*");
        // Largest settings: a 15 character type and a 255 character payload still frame.
        set_limits(15, 255);
        send_message(15, 255, 1'b1, 1'b1);
        send_message(16, 0, 1'b1, 1'b1);
        send_message(15, 0, 1'b0, 1'b1);
        send_message(15, 3, 1'b1, 1'b1);
        // Writes to the unused indexes must leave both limits alone.
        drain();
        cfg_write(REG_RESERVED_LO, 8'h00);
        cfg_write(REG_RESERVED_HI, 8'hFF);
        send_message(15, 2, 1'b1, 1'b1);
        send_message(16, 0, 1'b1, 1'b1);
    endtask

    // Random traffic: mostly well-formed messages sized around the current limits, the
    // rest truncated messages and delimiter-heavy noise. The limits change now and then,
    // each change waiting for the block to drain.
    task automatic run_random_phase(input int src_pct, input int snk_pct, input int events);
        int goal;
        int pick;
        int tlen;
        int plen;
        drain();
        src_idle_pct = src_pct;
        sink_idle_pct <= snk_pct;
        set_limits($urandom_range(1, 15), $urandom_range(1, 12));
        goal = framed_count + events;
        while (framed_count < goal) begin
            if ($urandom_range(9) == 0) begin
                set_limits(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 15),
                           ($urandom_range(9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 12));
            end
            tlen = $urandom_range(0, cur_tlim + 1);
            plen = $urandom_range(0, ((cur_plim < 12) ? cur_plim : 12) + 1);
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_message(tlen, plen, $urandom_range(5) != 0, 1'b1);
            end else begin
                if (pick < 85) begin
                    send_message(tlen, plen, 1'($urandom), 1'b0);
                end
                repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            end
        end
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering characters,
    // so the block fills up and has to hold off its input.
    task automatic test_backpressure();
        drain();
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        hold_req <= hold_req + 1;
        set_limits(6, 20);
        repeat (12) send_message($urandom_range(1, 6), $urandom_range(0, 8), 1'b1, 1'b1);
        drain();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_limits();
        run_random_phase(15, 75, 30);
        run_random_phase(75, 15, 30);
        run_random_phase(0, 0, 30);
        test_backpressure();

        drain();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/dmp_pkg.sv
sv/dmp_cfg_regs.sv
sv/dmp_framer.sv
sv/delimited_message_parser.sv
verif/tb_top.sv
